// File: src/matrix_inverse_3x3_assert.svh
// Assertion macros for the checker file of the 3x3 matrix inverse.
// Each macro expects signals named clk and rst where it is used.
`ifndef MATRIX_INVERSE_3X3_ASSERT_SVH
`define MATRIX_INVERSE_3X3_ASSERT_SVH

// The consequent must hold at every edge at which the antecedent holds.
`define MI3_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("matrix_inverse_3x3: implication check failed");

// The expression must never be true outside reset.
`define MI3_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("matrix_inverse_3x3: forbidden condition seen");

`endif

// File: src/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// Types and fixed widths shared by the 3x3 matrix inverse datapath.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int ELEM_W = 32;   // matrix element
  localparam int PROD_W = 64;   // element product
  localparam int COF_W  = 65;   // exact cofactor, signed
  localparam int MAG_W  = 64;   // cofactor magnitude
  localparam int TERM_W = 96;   // element times cofactor magnitude
  localparam int DET_W  = 97;   // exact determinant
  localparam int DETV_W = 64;   // rounded determinant field
  localparam int QBITS  = 33;   // quotient bits resolved by the divider

  // Cycles from the input transfer to the merge stage inputs.
  localparam int PIPE_LAT   = 9 + QBITS;
  localparam int RESULT_LAT = PIPE_LAT + 1;

  localparam logic [1:0] KIND_ADJ  = 2'd0;
  localparam logic [1:0] KIND_INV  = 2'd1;
  localparam logic [1:0] KIND_TINV = 2'd2;

  typedef logic signed [ELEM_W-1:0] elem_t;

  typedef struct packed {
    logic [1:0] kind;
    elem_t      m_xx;
    elem_t      m_xy;
    elem_t      m_xz;
    elem_t      m_yx;
    elem_t      m_yy;
    elem_t      m_yz;
    elem_t      m_zx;
    elem_t      m_zy;
    elem_t      m_zz;
  } in_t;

  typedef struct packed {
    elem_t                    out_xx;
    elem_t                    out_xy;
    elem_t                    out_xz;
    elem_t                    out_yx;
    elem_t                    out_yy;
    elem_t                    out_yz;
    elem_t                    out_zx;
    elem_t                    out_zy;
    elem_t                    out_zz;
    logic signed [DETV_W-1:0] det_value;
    logic                     singular;
  } out_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
  } cof_t;

  typedef struct packed {
    logic [DET_W-1:0] mag;
    logic             neg;
  } det_info_t;

endpackage

// File: src/matrix_inverse_3x3.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// 3x3 adjugate, inverse and transposed inverse of a signed fixed-point matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Drive cmd with the kind and the nine elements and raise start; the
//   transfer takes place at a rising edge where start is high and busy is
//   low. busy is high only during reset and in the cycle after it, so a new
//   matrix can be transferred on every cycle: one matrix per clock.
//   Each result appears on result for exactly one cycle with done high, in
//   the order the matrices went in. In each of the nine element lanes a
//   divider resolves one quotient bit per stage over 33 stages, behind
//   three cofactor stages and four determinant stages.
//   The receiver cannot hold results off; nothing stalls inside the block.
//   Reset empties the pipeline: matrices in flight produce no result.
//   A zero determinant with an inversion kind gives a zero matrix, a zero
//   determinant and the singular flag.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  mi3_pkg::in_t  cmd,
  output logic          done,
  output mi3_pkg::out_t result
);
  import mi3_pkg::*;

  logic               accept;
  logic               vpipe [PIPE_LAT];
  logic [1:0]         kpipe [PIPE_LAT];
  elem_t              m     [3][3];
  cof_t               cof   [9];
  cof_t               det_cof [3];
  det_info_t          dinfo;
  logic signed [DETV_W-1:0] det_v;
  logic               det_z;
  logic signed [DETV_W-1:0] dv_p [QBITS+1];
  logic               dz_p [QBITS+1];
  elem_t              adj_val [9];
  elem_t              inv_val [9];

  assign accept = start && !busy;

  assign m[0][0] = cmd.m_xx;
  assign m[0][1] = cmd.m_xy;
  assign m[0][2] = cmd.m_xz;
  assign m[1][0] = cmd.m_yx;
  assign m[1][1] = cmd.m_yy;
  assign m[1][2] = cmd.m_yz;
  assign m[2][0] = cmd.m_zx;
  assign m[2][1] = cmd.m_zy;
  assign m[2][2] = cmd.m_zz;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PIPE_LAT; k++) begin
        vpipe[k] <= 1'b0;
      end
    end else begin
      vpipe[0] <= accept;
      for (int k = 1; k < PIPE_LAT; k++) begin
        vpipe[k] <= vpipe[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    kpipe[0] <= cmd.kind;
    for (int k = 1; k < PIPE_LAT; k++) begin
      kpipe[k] <= kpipe[k-1];
    end
    dv_p[0] <= det_v;
    dz_p[0] <= det_z;
    for (int k = 1; k <= QBITS; k++) begin
      dv_p[k] <= dv_p[k-1];
      dz_p[k] <= dz_p[k-1];
    end
  end

  // Lane (i,j) holds the cofactor of element (j,i), so the lanes read as
  // the adjugate in row-major order.
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      mi3_cof_lane u_cof (
        .clk (clk),
        .a   (m[(j+1)%3][(i+1)%3]),
        .b   (m[(j+2)%3][(i+2)%3]),
        .c   (m[(j+1)%3][(i+2)%3]),
        .d   (m[(j+2)%3][(i+1)%3]),
        .cof (cof[i*3+j])
      );

      mi3_div_lane #(
        .FRAC_BITS (FRAC_BITS)
      ) u_div (
        .clk     (clk),
        .cof     (cof[i*3+j]),
        .dinfo   (dinfo),
        .adj_val (adj_val[i*3+j]),
        .inv_val (inv_val[i*3+j])
      );
    end
  end

  assign det_cof[0] = cof[0];
  assign det_cof[1] = cof[3];
  assign det_cof[2] = cof[6];

  mi3_det #(
    .FRAC_BITS (FRAC_BITS)
  ) u_det (
    .clk       (clk),
    .row0      (m[0]),
    .cof       (det_cof),
    .dinfo     (dinfo),
    .det_value (det_v),
    .det_zero  (det_z)
  );

  mi3_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .valid     (vpipe[PIPE_LAT-1]),
    .kind      (kpipe[PIPE_LAT-1]),
    .adj_val   (adj_val),
    .inv_val   (inv_val),
    .det_value (dv_p[QBITS]),
    .det_zero  (dz_p[QBITS]),
    .done      (done),
    .result    (result)
  );

endmodule

// File: src/mi3_cof_lane.sv
// ----------------------------------------------------------------------------
// mi3_cof_lane
// One cofactor: two element products, their difference, then sign and
// magnitude. Three register stages.
// ----------------------------------------------------------------------------
module mi3_cof_lane (
  input  logic           clk,
  input  mi3_pkg::elem_t a,
  input  mi3_pkg::elem_t b,
  input  mi3_pkg::elem_t c,
  input  mi3_pkg::elem_t d,
  output mi3_pkg::cof_t  cof
);
  import mi3_pkg::*;

  logic signed [PROD_W-1:0] p1;
  logic signed [PROD_W-1:0] p2;
  logic signed [COF_W-1:0]  diff;

  always_ff @(posedge clk) begin
    p1       <= PROD_W'(a) * PROD_W'(b);
    p2       <= PROD_W'(c) * PROD_W'(d);
    diff     <= COF_W'(p1) - COF_W'(p2);
    cof.neg  <= diff[COF_W-1];
    cof.mag  <= diff[COF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
  end

endmodule

// File: src/mi3_det.sv
// ----------------------------------------------------------------------------
// mi3_det
// Merges the cofactors of the first row (the first adjugate column) with the first row into the exact
// determinant, and rounds it to the output format.
// ----------------------------------------------------------------------------
module mi3_det #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  mi3_pkg::elem_t                 row0 [3],
  input  mi3_pkg::cof_t                  cof  [3],
  output mi3_pkg::det_info_t             dinfo,
  output logic signed [mi3_pkg::DETV_W-1:0] det_value,
  output logic                           det_zero
);
  import mi3_pkg::*;

  localparam int RW = DET_W + 1;
  localparam logic [RW-1:0] HALF = RW'(1) << (FRAC_BITS - 1);

  logic [ELEM_W-1:0] xm [3][3];
  logic              xs [3][3];
  logic [PROD_W-1:0] pl [3];
  logic [PROD_W-1:0] ph [3];
  logic              ps [3];
  logic [TERM_W-1:0] tm [3];
  logic              ts [3];
  logic [DET_W-1:0]  det;
  logic [DET_W-1:0]  det_sum;
  logic              zero_q;
  logic [RW-1:0]     rnd;
  logic [RW-1:0]     lim;
  logic [RW-1:0]     mag_sat;

  // Row elements wait here until their cofactors arrive.
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      xm[0][j] <= row0[j][ELEM_W-1] ? ELEM_W'(-row0[j]) : ELEM_W'(row0[j]);
      xs[0][j] <= row0[j][ELEM_W-1];
      xm[1][j] <= xm[0][j];
      xs[1][j] <= xs[0][j];
      xm[2][j] <= xm[1][j];
      xs[2][j] <= xs[1][j];
      pl[j]    <= PROD_W'(xm[2][j]) * PROD_W'(cof[j].mag[31:0]);
      ph[j]    <= PROD_W'(xm[2][j]) * PROD_W'(cof[j].mag[63:32]);
      ps[j]    <= xs[2][j] ^ cof[j].neg;
      tm[j]    <= {ph[j], 32'd0} + TERM_W'(pl[j]);
      ts[j]    <= ps[j];
    end
  end

  always_comb begin
    det_sum = '0;
    for (int j = 0; j < 3; j++) begin
      det_sum = det_sum + (ts[j] ? DET_W'(-DET_W'(tm[j])) : DET_W'(tm[j]));
    end
  end

  always_comb begin
    rnd     = (RW'(dinfo.mag) + HALF) >> FRAC_BITS;
    lim     = (RW'(1) << (DETV_W - 1)) - RW'(!dinfo.neg);
    mag_sat = (rnd > lim) ? lim : rnd;
  end

  always_ff @(posedge clk) begin
    det       <= det_sum;
    dinfo.neg <= det[DET_W-1];
    dinfo.mag <= det[DET_W-1] ? DET_W'(-det) : det;
    zero_q    <= (det == '0);
    det_value <= dinfo.neg ? DETV_W'(-mag_sat) : DETV_W'(mag_sat);
    det_zero  <= zero_q;
  end

endmodule

// File: src/mi3_div_lane.sv
// ----------------------------------------------------------------------------
// mi3_div_lane
// Per-element result lane: rounds the cofactor for the adjugate and runs a
// restoring divider, one quotient bit per stage, for the inverse.
// ----------------------------------------------------------------------------
module mi3_div_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  mi3_pkg::cof_t      cof,
  input  mi3_pkg::det_info_t dinfo,
  output mi3_pkg::elem_t     adj_val,
  output mi3_pkg::elem_t     inv_val
);
  import mi3_pkg::*;

  localparam int AW  = MAG_W + 1;
  localparam int XW  = DET_W + QBITS + 1;
  localparam int QW  = QBITS + 1;
  localparam int PRE = 4;
  localparam logic [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);

  logic [MAG_W-1:0] mag_d [PRE];
  logic             neg_d [PRE];
  elem_t            adj_d [PRE];
  elem_t            adj_p [QBITS+2];

  logic [XW-1:0]    r   [QBITS+1];
  logic [QBITS-1:0] q   [QBITS+1];
  logic [DET_W-1:0] dmp [QBITS+1];
  logic             ovf [QBITS+1];
  logic             sg  [QBITS+1];

  logic [AW-1:0] a_rnd;
  logic [AW-1:0] a_lim;
  logic [AW-1:0] a_mag;
  logic [XW-1:0] num;
  logic          rup;
  logic [QW-1:0] qr;
  logic [QW-1:0] q_lim;
  logic [QW-1:0] q_mag;

  always_comb begin
    a_rnd = (AW'(cof.mag) + HALF) >> FRAC_BITS;
    a_lim = (AW'(1) << (ELEM_W - 1)) - AW'(!cof.neg);
    a_mag = (a_rnd > a_lim) ? a_lim : a_rnd;
    num   = XW'(mag_d[PRE-1]) << (2 * FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    mag_d[0] <= cof.mag;
    neg_d[0] <= cof.neg;
    adj_d[0] <= cof.neg ? ELEM_W'(-a_mag) : ELEM_W'(a_mag);
    for (int k = 1; k < PRE; k++) begin
      mag_d[k] <= mag_d[k-1];
      neg_d[k] <= neg_d[k-1];
      adj_d[k] <= adj_d[k-1];
    end
    adj_p[0] <= adj_d[PRE-1];
    for (int k = 1; k < QBITS + 2; k++) begin
      adj_p[k] <= adj_p[k-1];
    end
    // Quotients at or above two to the quotient width saturate anyway.
    r[0]   <= num;
    q[0]   <= '0;
    dmp[0] <= dinfo.mag;
    ovf[0] <= num >= (XW'(dinfo.mag) << QBITS);
    sg[0]  <= neg_d[PRE-1] ^ dinfo.neg;
  end

  for (genvar s = 1; s <= QBITS; s++) begin : g_stage
    logic [XW-1:0] trial;
    assign trial = XW'(dmp[s-1]) << (QBITS - s);
    always_ff @(posedge clk) begin
      if (r[s-1] >= trial) begin
        r[s] <= r[s-1] - trial;
        q[s] <= q[s-1] | (QBITS'(1) << (QBITS - s));
      end else begin
        r[s] <= r[s-1];
        q[s] <= q[s-1];
      end
      dmp[s] <= dmp[s-1];
      ovf[s] <= ovf[s-1];
      sg[s]  <= sg[s-1];
    end
  end

  always_comb begin
    rup   = (r[QBITS] << 1) >= XW'(dmp[QBITS]);
    qr    = QW'(q[QBITS]) + QW'(rup);
    q_lim = (QW'(1) << (ELEM_W - 1)) - QW'(!sg[QBITS]);
    q_mag = (ovf[QBITS] || (qr > q_lim)) ? q_lim : qr;
  end

  always_ff @(posedge clk) begin
    inv_val <= sg[QBITS] ? ELEM_W'(-q_mag) : ELEM_W'(q_mag);
  end

  assign adj_val = adj_p[QBITS+1];

endmodule

// File: src/mi3_merge.sv
// ----------------------------------------------------------------------------
// mi3_merge
// Picks adjugate, inverse or transposed inverse from the lanes, applies the
// singular case and registers the result.
// ----------------------------------------------------------------------------
module mi3_merge (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            valid,
  input  logic [1:0]                      kind,
  input  mi3_pkg::elem_t                  adj_val [9],
  input  mi3_pkg::elem_t                  inv_val [9],
  input  logic signed [mi3_pkg::DETV_W-1:0] det_value,
  input  logic                            det_zero,
  output logic                            done,
  output mi3_pkg::out_t                   result
);
  import mi3_pkg::*;

  logic  inv;
  logic  sing;
  elem_t sel [9];

  always_comb begin
    inv  = (kind == KIND_INV) || (kind == KIND_TINV);
    sing = inv && det_zero;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (sing) begin
          sel[i*3+j] = '0;
        end else if (!inv) begin
          sel[i*3+j] = adj_val[i*3+j];
        end else if (kind == KIND_TINV) begin
          sel[i*3+j] = inv_val[j*3+i];
        end else begin
          sel[i*3+j] = inv_val[i*3+j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid;
    end
  end

  always_ff @(posedge clk) begin
    result.out_xx    <= sel[0];
    result.out_xy    <= sel[1];
    result.out_xz    <= sel[2];
    result.out_yx    <= sel[3];
    result.out_yy    <= sel[4];
    result.out_yz    <= sel[5];
    result.out_zx    <= sel[6];
    result.out_zy    <= sel[7];
    result.out_zz    <= sel[8];
    result.det_value <= sing ? '0 : det_value;
    result.singular  <= sing;
  end

endmodule

// File: src/mi3_check.sv
// ----------------------------------------------------------------------------
// mi3_check
// Port-level checks of the 3x3 matrix inverse, bound to the top level.
// ----------------------------------------------------------------------------
`include "matrix_inverse_3x3_assert.svh"

module mi3_check (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input mi3_pkg::in_t  cmd,
  input logic          done,
  input mi3_pkg::out_t result
);
  import mi3_pkg::*;

  // Every result goes back to a transfer a fixed number of cycles earlier.
  `MI3_ASSERT_IMP(a_done_has_transfer, done, $past(start && !busy, RESULT_LAT))

  // A singular result carries a zero determinant.
  `MI3_ASSERT_NEVER(a_singular_det, done && result.singular && (result.det_value != '0))

  // Only an inversion request can be flagged singular.
  `MI3_ASSERT_IMP(a_singular_kind, done && result.singular, ($past(cmd.kind, RESULT_LAT) == KIND_INV) || ($past(cmd.kind, RESULT_LAT) == KIND_TINV))

  // No transfer is taken in the cycle after reset.
  `MI3_ASSERT_IMP(a_busy_after_reset, $past(rst), busy)

endmodule

bind matrix_inverse_3x3 mi3_check u_check (.*);
